// ===== sv/stc_pkg.sv =====
`default_nettype none
package stc_pkg;

    localparam logic [32:0] NS_PER_SEC   = 33'd1000000000;
    localparam int          MAX_MEMBERS  = 16;
    localparam int          FLAG_TEN     = 2;
    localparam int          FLAG_RANDOM  = 3;

    localparam logic [1:0]  KIND_NORMAL  = 2'd0;
    localparam logic [1:0]  KIND_TEN     = 2'd1;
    localparam logic [1:0]  KIND_RANDOM  = 2'd2;

    localparam logic [1:0]  REG_WINDOW   = 2'd0;
    localparam logic [1:0]  REG_MIN_ST   = 2'd1;
    localparam logic [1:0]  REG_PERIOD   = 2'd2;

    localparam logic [0:0]  FUNC_HIT     = 1'b0;
    localparam logic [0:0]  FUNC_FLUSH   = 1'b1;

    typedef struct packed {
        logic [31:0] second;
        logic [29:0] nanosecond;
        logic [15:0] station;
        logic [3:0]  flags;
        logic [15:0] index;
        logic        used;
        logic        member;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EVAL   = 7'b0000010,
        ST_START  = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_DECIDE = 7'b0010000,
        ST_EMIT   = 7'b0100000,
        ST_POP    = 7'b1000000
    } state_t;

    // true when (s, ns) lies outside the window opened at (s0, ns0)
    function automatic logic beyond(input logic [31:0] s, input logic [29:0] ns,
                                    input logic [31:0] s0, input logic [29:0] ns0,
                                    input logic [29:0] win);
        logic [31:0] sd;
        logic [32:0] d;
        sd = s - s0;
        d  = {3'b000, ns} + (sd[0] ? NS_PER_SEC : 33'd0) - {3'b000, ns0};
        if (sd > 32'd1)
            return 1'b1;
        if (d[32])
            return 1'b1;
        return d > {3'b000, win};
    endfunction

endpackage
`default_nettype wire

// ===== sv/stc_cell.sv =====
`default_nettype none
module stc_cell (
    input  wire                 clk,
    input  stc_pkg::cell_ctrl_t ctrl,
    input  stc_pkg::entry_t     shift_in,
    input  stc_pkg::entry_t     load_in,
    output stc_pkg::entry_t     q
);
    import stc_pkg::*;

    entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            q_reg <= load_in;
        else if (ctrl.shift)
            q_reg <= shift_in;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ===== sv/station_coincidence_trigger.sv =====
// path: IDLE then EVAL for each hit or flush; a used seed adds START, POP;
// a judged seed START, SCAN, DECIDE, POP; a fired event adds EMIT plus output stalls
// throughput: one input transfer at a time, set by the cell chain rotations
// (scan pass, then emit pass when the group fires) for each judged seed
// reset: rst_n asynchronous active low; clears control, counters, flags and
// the duplicate key valid flag; pending cell payloads are not cleared
`default_nettype none
module station_coincidence_trigger #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // station[15:0], hit_second[47:16], hit_nanosecond[77:48],
    // trig_flags[81:78], hit_index[97:82], zero fill
    input  wire  [103:0] s_tdata,
    // func[0]
    input  wire  [0:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // event_number[31:0], member_station[47:32], member_second[79:48],
    // member_nanosecond[109:80], member_index[125:110], overflow_seen[126], zero fill
    output logic [127:0] m_tdata,
    // event_kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [3:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import stc_pkg::*;

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = $clog2(BUFFER_DEPTH);

    // configuration registers
    logic [29:0] window_reg;
    logic [4:0]  min_st_reg;
    logic [15:0] period_reg;

    // control state
    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] step_reg, step_next;
    logic [15:0] rand_reg, rand_next;
    logic [31:0] evcnt_reg, evcnt_next;
    logic        ovf_reg, ovf_next;
    logic        last_vld_reg, last_vld_next;
    logic [31:0] last_sec_reg;
    logic [29:0] last_ns_reg;
    logic [15:0] last_st_reg;
    logic [4:0]  nmem_reg, nmem_next;
    logic [4:0]  nstat_reg, nstat_next;
    logic [4:0]  emitted_reg, emitted_next;
    logic        broken_reg, broken_next;
    logic [MAX_MEMBERS-1:0] stn_vld_reg, stn_vld_next;
    logic [15:0] stn_reg [MAX_MEMBERS];

    // latched input transfer
    logic        in_func_reg;
    entry_t      in_reg;

    // seed of the window being judged
    logic [31:0] s0_sec_reg;
    logic [29:0] s0_ns_reg;
    logic        seed_ten_reg;
    logic        seed_rnd_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [127:0] m_data_reg;
    logic [1:0]  m_kind_reg;
    logic        m_last_reg;

    // cell chain wiring
    entry_t      cell_q [BUFFER_DEPTH];
    entry_t      wrap_entry;
    entry_t      load_entry;
    logic        shift_en;
    logic        load_en;

    // per-cycle decisions
    entry_t      head;
    logic        dup;
    logic        closed;
    logic        k_in;
    logic        b_scan;
    logic        is_mem;
    logic        known;
    logic        fire;
    logic        out_free;
    logic        out_load;
    logic        last_step;
    logic [15:0] rand_inc;
    logic        seed_grab;
    logic        stn_add;

    assign head      = cell_q[0];
    assign last_step = (step_reg == SW'(BUFFER_DEPTH - 1));
    assign out_free  = !m_valid_reg || m_tready;
    assign rand_inc  = rand_reg + 16'd1;

    // the chain: cell i takes cell i+1, the last takes the modified head
    for (genvar i = 0; i < BUFFER_DEPTH; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        entry_t     nb;
        assign ctrl.shift = shift_en;
        assign ctrl.load  = load_en && (count_reg == CW'(i));
        if (i == BUFFER_DEPTH - 1)
        begin : g_tail
            assign nb = wrap_entry;
        end
        else
        begin : g_mid
            assign nb = cell_q[i+1];
        end
        stc_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .shift_in (nb),
            .load_in  (load_entry),
            .q        (cell_q[i])
        );
    end

    // duplicate and window close test for the latched transfer
    assign dup = last_vld_reg && last_sec_reg == in_reg.second &&
                 last_ns_reg == in_reg.nanosecond && last_st_reg == in_reg.station;

    always_comb
    begin
        if (in_func_reg == FUNC_FLUSH)
            closed = (count_reg != '0);
        else
            closed = (count_reg != '0) &&
                     beyond(in_reg.second, in_reg.nanosecond,
                            head.second, head.nanosecond, window_reg);
    end

    // scan pass: head entry examined as it wraps to the tail
    assign k_in   = (CW'(step_reg) < count_reg);
    assign b_scan = beyond(head.second, head.nanosecond, s0_sec_reg, s0_ns_reg, window_reg);
    assign is_mem = k_in && !broken_reg && !b_scan &&
                    (head.flags[FLAG_TEN] == seed_ten_reg) &&
                    (nmem_reg < 5'(MAX_MEMBERS));

    always_comb
    begin
        known = 1'b0;
        for (int j = 0; j < MAX_MEMBERS; j++)
            if (stn_vld_reg[j] && stn_reg[j] == head.station)
                known = 1'b1;
    end

    assign fire = (nmem_reg >= min_st_reg && nstat_reg >= min_st_reg) ||
                  seed_ten_reg || seed_rnd_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        rand_next     = rand_reg;
        evcnt_next    = evcnt_reg;
        ovf_next      = ovf_reg;
        last_vld_next = last_vld_reg;
        nmem_next     = nmem_reg;
        nstat_next    = nstat_reg;
        emitted_next  = emitted_reg;
        broken_next   = broken_reg;
        stn_vld_next  = stn_vld_reg;
        shift_en      = 1'b0;
        load_en       = 1'b0;
        out_load      = 1'b0;
        seed_grab     = 1'b0;
        stn_add       = 1'b0;
        wrap_entry    = head;
        load_entry    = in_reg;
        load_entry.used   = 1'b0;
        load_entry.member = 1'b0;
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (in_func_reg == FUNC_HIT && !dup)
                begin
                    if (count_reg == CW'(BUFFER_DEPTH))
                        ovf_next = 1'b1;
                    else
                    begin
                        // every random_period-th stored hit gets the random flag
                        load_en       = 1'b1;
                        count_next    = count_reg + CW'(1);
                        last_vld_next = 1'b1;
                        rand_next     = rand_inc;
                        if (period_reg != '0 && rand_inc >= period_reg)
                        begin
                            rand_next = '0;
                            load_entry.flags[FLAG_RANDOM] = 1'b1;
                        end
                    end
                end
                state_next = closed ? ST_START : ST_IDLE;
            end
            ST_START:
            begin
                if (head.used)
                    state_next = ST_POP;
                else
                begin
                    seed_grab    = 1'b1;
                    nmem_next    = '0;
                    nstat_next   = '0;
                    broken_next  = 1'b0;
                    stn_vld_next = '0;
                    step_next    = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                shift_en          = 1'b1;
                wrap_entry.member = is_mem;
                if (k_in && !broken_reg && b_scan)
                    broken_next = 1'b1;
                if (is_mem)
                begin
                    nmem_next = nmem_reg + 5'd1;
                    if (!known)
                    begin
                        stn_add    = 1'b1;
                        nstat_next = nstat_reg + 5'd1;
                        stn_vld_next[nstat_reg[3:0]] = 1'b1;
                    end
                end
                step_next = step_reg + SW'(1);
                if (last_step)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                step_next    = '0;
                emitted_next = '0;
                state_next   = fire ? ST_EMIT : ST_POP;
            end
            ST_EMIT:
            begin
                if (!head.member || out_free)
                begin
                    shift_en          = 1'b1;
                    wrap_entry.member = 1'b0;
                    if (head.member)
                    begin
                        out_load        = 1'b1;
                        wrap_entry.used = 1'b1;
                        emitted_next    = emitted_reg + 5'd1;
                    end
                    step_next = step_reg + SW'(1);
                    if (last_step)
                    begin
                        evcnt_next = evcnt_reg + 32'd1;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                // seed leaves the head and parks beyond the fill count
                shift_en   = 1'b1;
                count_next = count_reg - CW'(1);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            step_reg     <= '0;
            rand_reg     <= '0;
            evcnt_reg    <= '0;
            ovf_reg      <= 1'b0;
            last_vld_reg <= 1'b0;
            nmem_reg     <= '0;
            nstat_reg    <= '0;
            emitted_reg  <= '0;
            broken_reg   <= 1'b0;
            stn_vld_reg  <= '0;
            m_valid_reg  <= 1'b0;
            window_reg   <= 30'd5000;
            min_st_reg   <= 5'd3;
            period_reg   <= 16'd0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            step_reg     <= step_next;
            rand_reg     <= rand_next;
            evcnt_reg    <= evcnt_next;
            ovf_reg      <= ovf_next;
            last_vld_reg <= last_vld_next;
            nmem_reg     <= nmem_next;
            nstat_reg    <= nstat_next;
            emitted_reg  <= emitted_next;
            broken_reg   <= broken_next;
            stn_vld_reg  <= stn_vld_next;
            m_valid_reg  <= m_valid_next;
            if (psel && penable && pwrite)
            begin
                unique case (paddr[3:2])
                    REG_WINDOW: window_reg <= pwdata[29:0];
                    REG_MIN_ST: min_st_reg <= pwdata[4:0];
                    REG_PERIOD: period_reg <= pwdata[15:0];
                    default:    ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg       <= s_tuser[0];
            in_reg.station    <= s_tdata[15:0];
            in_reg.second     <= s_tdata[47:16];
            in_reg.nanosecond <= s_tdata[77:48];
            in_reg.flags      <= s_tdata[81:78];
            in_reg.index      <= s_tdata[97:82];
            in_reg.used       <= 1'b0;
            in_reg.member     <= 1'b0;
        end
        if (load_en)
        begin
            last_sec_reg <= in_reg.second;
            last_ns_reg  <= in_reg.nanosecond;
            last_st_reg  <= in_reg.station;
        end
        if (seed_grab)
        begin
            s0_sec_reg   <= head.second;
            s0_ns_reg    <= head.nanosecond;
            seed_ten_reg <= head.flags[FLAG_TEN];
            seed_rnd_reg <= head.flags[FLAG_RANDOM];
        end
        if (stn_add)
            stn_reg[nstat_reg[3:0]] <= head.station;
        if (out_load)
        begin
            m_data_reg <= {1'b0, ovf_reg, head.index, head.nanosecond,
                           head.second, head.station, evcnt_reg};
            m_kind_reg <= seed_ten_reg ? KIND_TEN : (seed_rnd_reg ? KIND_RANDOM : KIND_NORMAL);
            m_last_reg <= (emitted_reg + 5'd1 == nmem_reg);
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WINDOW: prdata = {2'b00, window_reg};
            REG_MIN_ST: prdata = {27'd0, min_st_reg};
            REG_PERIOD: prdata = {16'd0, period_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

// ===== sv/stc_checker.sv =====
`default_nettype none
module stc_checker (
    input wire         clk,
    input wire         rst_n,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [127:0] m_tdata,
    input wire [1:0]   m_tuser,
    input wire         m_tlast
);
    logic        seen_reg;
    logic        prev_last_reg;
    logic [31:0] prev_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_last_reg <= 1'b0;
            prev_num_reg  <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            seen_reg      <= 1'b1;
            prev_last_reg <= m_tlast;
            prev_num_reg  <= m_tdata[31:0];
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
        $stable(m_tuser))
        else $error("stalled result changed");

    // members of one event share its number
    a_same_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && seen_reg && !prev_last_reg |->
        m_tdata[31:0] == prev_num_reg)
        else $error("event number changed inside an event");

    // events are numbered consecutively
    a_next_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && seen_reg && prev_last_reg |->
        m_tdata[31:0] == prev_num_reg + 32'd1)
        else $error("event number skipped");

    // one input transfer is worked on at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

endmodule

bind station_coincidence_trigger stc_checker u_stc_checker (.*);
`default_nettype wire
